FILE: rtl/twms_pkg.sv
// ----------------------------------------------------------------------------
// twms_pkg
// Shared types and codes of the two-stage machine list scheduler.
// ----------------------------------------------------------------------------
package twms_pkg;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 11;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_JOB   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_WASH = 2'd2;

  localparam logic REG_DRYER_COUNT  = 1'b0;
  localparam logic REG_DRY_DURATION = 1'b1;

  typedef struct packed {
    logic [1:0]          action;
    logic [PERIOD_W-1:0] wash_period;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] job_finish;
    logic [TIME_W-1:0] latest_finish;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_SET_FULL,
    OP_SET_NO_WASH,
    OP_W_INS,
    OP_UP_RD,
    OP_UP_CMP,
    OP_PUT,
    OP_RD_ROOT,
    OP_W_RD_PER,
    OP_W_POP_INIT,
    OP_DN_RDL,
    OP_DN_RDR,
    OP_DN_CMP,
    OP_D_DECIDE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   dryer;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       w_full;
    logic       w_empty;
    logic       d_empty;
    logic       i_zero;
    logic       l_in;
    logic       up_less;
    logic       dn_move;
    logic       fresh;
  } dp_sts_t;

endpackage

FILE: rtl/two_stage_machine_list_scheduler.sv
// ----------------------------------------------------------------------------
// two_stage_machine_list_scheduler
// Washer min-heap pop/push plus dryer min-heap list scheduling, one item at
// a time, with a registered result held while the next item is taken.
// ----------------------------------------------------------------------------
// Load: a washer sift-up with one RAM read per level.
// Job: a washer pop with sift-down, then a dryer sift-up or sift-down; the
//   pace is set by the single read port of each heap RAM. Clear and error
//   items skip the heap loops.
// One item in flight; a new item is taken while the last result waits.
// Reset empties both heaps by count, zeroes latest finish, sets both regs to 1.
module two_stage_machine_list_scheduler #(
  parameter int WASHER_SLOTS = 1024,
  parameter int DRYER_SLOTS  = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  twms_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output twms_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import twms_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  twms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  twms_dp #(.WASHER_SLOTS(WASHER_SLOTS), .DRYER_SLOTS(DRYER_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
  );

  assign pready = 1'b1;

endmodule

FILE: rtl/twms_ram.sv
// ----------------------------------------------------------------------------
// twms_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/twms_ctrl.sv
// ----------------------------------------------------------------------------
// twms_ctrl
// Sequencer: dispatches items and steps the heap sift loops.
// ----------------------------------------------------------------------------
module twms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  twms_pkg::dp_sts_t sts,
  output twms_pkg::dp_cmd_t cmd
);
  import twms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_UP_CHK, S_UP_CMP, S_RD_PER, S_POP_INIT, S_DN_CHK,
    S_DN_RDR, S_DN_CMP, S_D_START, S_D_DECIDE, S_DONE
  } state_t;

  state_t state_r, state_nxt, fin_state;
  logic   sel_r, sel_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign fin_state = (!sel_r && sts.act == ACT_JOB) ? S_D_START : S_DONE;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd.op        = OP_NONE;
    cmd.dryer     = sel_r;
    cmd.emit      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        sel_nxt = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        case (sts.act)
          ACT_LOAD: begin
            if (sts.w_full) begin
              cmd.op = OP_SET_FULL;
            end else begin
              cmd.op    = OP_W_INS;
              state_nxt = S_UP_CHK;
            end
          end
          ACT_JOB: begin
            if (sts.w_empty) begin
              cmd.op = OP_SET_NO_WASH;
            end else begin
              cmd.op    = OP_RD_ROOT;
              state_nxt = S_RD_PER;
            end
          end
          ACT_CLEAR: cmd.op = OP_CLEAR;
          default:   cmd.op = OP_NONE;
        endcase
      end
      S_UP_CHK: begin
        if (sts.i_zero) begin
          cmd.op    = OP_PUT;
          state_nxt = fin_state;
        end else begin
          cmd.op    = OP_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.op    = OP_UP_CMP;
        state_nxt = sts.up_less ? S_UP_CHK : fin_state;
      end
      S_RD_PER: begin
        cmd.op    = OP_W_RD_PER;
        state_nxt = S_POP_INIT;
      end
      S_POP_INIT: begin
        cmd.op    = OP_W_POP_INIT;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.l_in) begin
          cmd.op    = OP_DN_RDL;
          state_nxt = S_DN_RDR;
        end else begin
          cmd.op    = OP_PUT;
          state_nxt = fin_state;
        end
      end
      S_DN_RDR: begin
        cmd.op    = OP_DN_RDR;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op    = OP_DN_CMP;
        state_nxt = sts.dn_move ? S_DN_CHK : fin_state;
      end
      S_D_START: begin
        cmd.dryer = 1'b1;
        cmd.op    = sts.d_empty ? OP_NONE : OP_RD_ROOT;
        state_nxt = S_D_DECIDE;
      end
      S_D_DECIDE: begin
        cmd.dryer = 1'b1;
        cmd.op    = OP_D_DECIDE;
        sel_nxt   = 1'b1;
        state_nxt = sts.fresh ? S_UP_CHK : S_DN_CHK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/twms_dp.sv
// ----------------------------------------------------------------------------
// twms_dp
// Datapath: heap memories, counters, sift registers and config registers.
// ----------------------------------------------------------------------------
module twms_dp #(
  parameter int WASHER_SLOTS = 1024,
  parameter int DRYER_SLOTS  = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  twms_pkg::dp_cmd_t   cmd,
  output twms_pkg::dp_sts_t   sts,
  input  twms_pkg::in_item_t  in_data,
  output twms_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata
);
  import twms_pkg::*;

  localparam int WAW = (WASHER_SLOTS > 1) ? $clog2(WASHER_SLOTS) : 1;
  localparam int DAW = (DRYER_SLOTS > 1) ? $clog2(DRYER_SLOTS) : 1;
  localparam int IW  = (WAW > DAW) ? WAW : DAW;
  localparam int WCW = WAW + 1;
  localparam int DCW = DAW + 1;
  localparam int XW  = IW + 2;
  localparam int WEW = TIME_W + WAW;

  function automatic logic key_less(input logic [TIME_W-1:0] at, input logic [WAW-1:0] aid,
                                    input logic [TIME_W-1:0] bt, input logic [WAW-1:0] bid);
    key_less = (at < bt) || ((at == bt) && (aid < bid));
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  logic [1:0]          act_r;
  logic [PERIOD_W-1:0] per_r;
  logic [WCW-1:0]      wtotal_r;
  logic [DCW-1:0]      dbusy_r;
  logic [TIME_W-1:0]   latest_r;
  logic [COUNT_W-1:0]  dcount_r;
  logic [PERIOD_W-1:0] ddur_r;
  logic [IW-1:0]       i_r;
  logic [TIME_W-1:0]   mov_t_r;
  logic [WAW-1:0]      mov_id_r;
  logic [TIME_W-1:0]   lt_r;
  logic [WAW-1:0]      lid_r;
  logic [TIME_W-1:0]   wend_r;
  logic [WAW-1:0]      wid_r;
  logic [1:0]          st_r;
  logic [TIME_W-1:0]   jfin_r;
  out_item_t           out_r;

  logic                w_we, d_we, p_we;
  logic [WAW-1:0]      w_raddr, w_waddr, p_raddr, p_waddr;
  logic [DAW-1:0]      d_raddr, d_waddr;
  logic [WEW-1:0]      w_wdata, w_rdata;
  logic [TIME_W-1:0]   d_wdata, d_rdata;
  logic [PERIOD_W-1:0] p_rdata;

  logic [XW-1:0]       n_x, l_x, r_x, p_x, m_x, ra_x;
  logic [IW-1:0]       p_i;
  logic [TIME_W-1:0]   rd_t, bt, ch_t, wr_t, droot, start, base, fin;
  logic [WAW-1:0]      rd_id, ch_id, wr_id;
  logic                r_in, lless, rless, up_less, dn_move, wr_en, fresh;
  logic [31:0]         cap32;
  logic                cfg_wr;

  twms_ram #(.WIDTH(WEW), .DEPTH(WASHER_SLOTS)) u_wheap (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  twms_ram #(.WIDTH(PERIOD_W), .DEPTH(WASHER_SLOTS)) u_wper (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(per_r),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  twms_ram #(.WIDTH(TIME_W), .DEPTH(DRYER_SLOTS)) u_dheap (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  assign rd_t  = cmd.dryer ? d_rdata : w_rdata[WEW-1:WAW];
  assign rd_id = cmd.dryer ? '0 : w_rdata[WAW-1:0];

  assign n_x = cmd.dryer ? XW'(dbusy_r) : XW'(wtotal_r);
  assign l_x = {1'b0, i_r, 1'b1};
  assign r_x = l_x + XW'(1);
  assign p_i = IW'((i_r - IW'(1)) >> 1);
  assign p_x = XW'(p_i);

  assign up_less = key_less(mov_t_r, mov_id_r, rd_t, rd_id);
  assign lless   = key_less(lt_r, lid_r, mov_t_r, mov_id_r);
  assign bt      = lless ? lt_r : mov_t_r;
  assign r_in    = r_x < n_x;
  assign rless   = r_in && key_less(rd_t, rd_id, bt, lless ? lid_r : mov_id_r);
  assign dn_move = lless || rless;
  assign ch_t    = rless ? rd_t : lt_r;
  assign ch_id   = rless ? rd_id : lid_r;
  assign m_x     = rless ? r_x : l_x;

  assign cap32 = (32'(dcount_r) > 32'(DRYER_SLOTS)) ? 32'(DRYER_SLOTS) : 32'(dcount_r);
  assign droot = d_rdata;
  assign fresh = (dbusy_r == '0) || ((droot > wend_r) && (32'(dbusy_r) < cap32));
  assign start = fresh ? '0 : droot;
  assign base  = (start > wend_r) ? start : wend_r;
  assign fin   = sat_add(base, TIME_W'(ddur_r));

  always_comb begin
    ra_x  = '0;
    wr_en = 1'b0;
    wr_t  = mov_t_r;
    wr_id = mov_id_r;
    case (cmd.op)
      OP_UP_RD:  ra_x = p_x;
      OP_DN_RDL: ra_x = l_x;
      OP_DN_RDR: ra_x = r_x;
      OP_PUT:    wr_en = 1'b1;
      OP_UP_CMP: begin
        wr_en = 1'b1;
        if (up_less) begin
          wr_t  = rd_t;
          wr_id = rd_id;
        end
      end
      OP_DN_CMP: begin
        wr_en = 1'b1;
        if (dn_move) begin
          wr_t  = ch_t;
          wr_id = ch_id;
        end
      end
      default: ra_x = '0;
    endcase
  end

  assign w_raddr = ra_x[WAW-1:0];
  assign d_raddr = ra_x[DAW-1:0];
  assign w_we    = wr_en && !cmd.dryer;
  assign d_we    = wr_en && cmd.dryer;
  assign w_waddr = i_r[WAW-1:0];
  assign d_waddr = i_r[DAW-1:0];
  assign w_wdata = {wr_t, wr_id};
  assign d_wdata = wr_t;
  assign p_we    = (cmd.op == OP_W_INS);
  assign p_waddr = wtotal_r[WAW-1:0];
  assign p_raddr = w_rdata[WAW-1:0];

  assign sts.act     = act_r;
  assign sts.w_full  = (wtotal_r == WCW'(WASHER_SLOTS));
  assign sts.w_empty = (wtotal_r == '0);
  assign sts.d_empty = (dbusy_r == '0);
  assign sts.i_zero  = (i_r == '0);
  assign sts.l_in    = l_x < n_x;
  assign sts.up_less = up_less;
  assign sts.dn_move = dn_move;
  assign sts.fresh   = fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtotal_r <= '0;
      dbusy_r  <= '0;
      latest_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          wtotal_r <= '0;
          dbusy_r  <= '0;
          latest_r <= '0;
        end
        OP_W_INS: wtotal_r <= wtotal_r + WCW'(1);
        OP_D_DECIDE: begin
          if (fresh) begin
            dbusy_r <= dbusy_r + DCW'(1);
          end
          if (fin > latest_r) begin
            latest_r <= fin;
          end
        end
        default: latest_r <= latest_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        act_r  <= in_data.action;
        per_r  <= in_data.wash_period;
        st_r   <= ST_OK;
        jfin_r <= '0;
      end
      OP_SET_FULL:    st_r <= ST_FULL;
      OP_SET_NO_WASH: st_r <= ST_NO_WASH;
      OP_W_INS: begin
        mov_t_r  <= TIME_W'(per_r);
        mov_id_r <= wtotal_r[WAW-1:0];
        i_r      <= IW'(wtotal_r);
      end
      OP_UP_CMP: begin
        if (up_less) begin
          i_r <= p_i;
        end
      end
      OP_W_RD_PER: begin
        wend_r <= w_rdata[WEW-1:WAW];
        wid_r  <= w_rdata[WAW-1:0];
      end
      OP_W_POP_INIT: begin
        mov_t_r  <= sat_add(wend_r, TIME_W'(p_rdata));
        mov_id_r <= wid_r;
        i_r      <= '0;
      end
      OP_DN_RDR: begin
        lt_r  <= rd_t;
        lid_r <= rd_id;
      end
      OP_DN_CMP: begin
        if (dn_move) begin
          i_r <= m_x[IW-1:0];
        end
      end
      OP_D_DECIDE: begin
        jfin_r   <= fin;
        mov_t_r  <= fin;
        mov_id_r <= '0;
        i_r      <= fresh ? IW'(dbusy_r) : '0;
      end
      default: i_r <= i_r;
    endcase
    if (cmd.emit) begin
      out_r.status        <= st_r;
      out_r.job_finish    <= jfin_r;
      out_r.latest_finish <= latest_r;
    end
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcount_r <= COUNT_W'(1);
      ddur_r   <= PERIOD_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DRYER_COUNT:  dcount_r <= pwdata[COUNT_W-1:0];
        REG_DRY_DURATION: ddur_r   <= pwdata;
        default:          ddur_r   <= ddur_r;
      endcase
    end
  end

  assign prdata   = (paddr[2] == REG_DRY_DURATION) ? ddur_r : 32'(dcount_r);
  assign out_data = out_r;

endmodule
